### src/dpms_pkg.sv
// Package for the device power mode sequencer: event and result transaction
// types, mode, link, event and register codes, and reset values.
// No dependencies.
package dpms_pkg;

  // Operating modes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_SLEEP    = 3'd1;
  localparam logic [2:0] MODE_SAMPLING = 3'd2;
  localparam logic [2:0] MODE_WIFI     = 3'd3;
  localparam logic [2:0] MODE_LTE      = 3'd4;
  localparam logic [2:0] MODE_GNSS     = 3'd5;
  localparam logic [2:0] MODE_ALARM    = 3'd6;
  localparam logic [2:0] MODE_CHARGING = 3'd7;

  // Active link kinds
  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_WIFI = 2'd1;
  localparam logic [1:0] LINK_PPP  = 2'd2;

  // Event codes (codes not listed change nothing)
  localparam logic [4:0] EV_BOOT        = 5'd0;
  localparam logic [4:0] EV_TIMER_WAKE  = 5'd1;
  localparam logic [4:0] EV_WIFI_UP     = 5'd3;
  localparam logic [4:0] EV_WIFI_DOWN   = 5'd4;
  localparam logic [4:0] EV_WIFI_FAIL   = 5'd5;
  localparam logic [4:0] EV_PPP_UP      = 5'd6;
  localparam logic [4:0] EV_PPP_DOWN    = 5'd7;
  localparam logic [4:0] EV_GPS_FIX     = 5'd10;
  localparam logic [4:0] EV_GPS_TIMEOUT = 5'd11;
  localparam logic [4:0] EV_EMERGENCY   = 5'd12;
  localparam logic [4:0] EV_CLEARED     = 5'd13;
  localparam logic [4:0] EV_CHARGER_ON  = 5'd14;
  localparam logic [4:0] EV_CHARGER_OFF = 5'd15;
  localparam logic [4:0] EV_CLOUD_CMD   = 5'd17;
  localparam logic [4:0] EV_SHUTDOWN    = 5'd18;

  // Configuration register indexes
  localparam logic REG_NORMAL_INTERVAL  = 1'b0;
  localparam logic REG_ANOMALY_INTERVAL = 1'b1;

  // Reset values of the intervals, in seconds
  localparam logic [31:0] NORMAL_INTERVAL_RST  = 32'd900;
  localparam logic [31:0] ANOMALY_INTERVAL_RST = 32'd300;

  typedef struct packed {
    logic [4:0]         event_code;
    logic signed [31:0] event_param;
  } event_t;

  typedef struct packed {
    logic [2:0]  prev_mode;
    logic [2:0]  next_mode;
    logic        transitioned;
    logic [1:0]  link_now;
    logic        emergency_now;
    logic [31:0] interval_now;
    logic        last;
  } result_t;

endpackage

### src/device_power_mode_sequencer_core.sv
// Device power mode sequencer top level: event rules, mode state and a
// two-entry result buffer. Depends on dpms_pkg.
//
// Latency: the first result of an event is valid the cycle after the event
// transaction. Throughput: one event per cycle when it yields one result and
// out_ready holds; an event with two results blocks the input while the
// second waits in a holding register for the output register.
// Reset (synchronous, active high): mode sleep, no link, no emergency,
// intervals 900 / 300 s, report interval 900 s, no results pending.
module device_power_mode_sequencer_core (
  input  logic              clk,
  input  logic              rst,
  // event channel
  input  logic              in_valid,
  output logic              in_ready,
  input  dpms_pkg::event_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output dpms_pkg::result_t out_data,
  // configuration write port
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  // Configuration registers
  logic [31:0] normal_interval;
  logic [31:0] anomaly_interval;

  // Sequencer state
  logic [2:0]  current_mode;
  logic [1:0]  link_kind;
  logic        emergency_active;
  logic [31:0] report_interval;

  // Result buffer: output register plus one holding register
  dpms_pkg::result_t out_reg;
  logic              out_vld;
  dpms_pkg::result_t hold_reg;
  logic              hold_vld;

  // Next-state and result logic
  logic              in_fire;
  logic              t1_en;
  logic [2:0]        t1_target;
  logic              tr1;
  logic              tr2;
  logic              rule2_en;
  logic [2:0]        mode1;
  logic [2:0]        mode_next;
  logic [1:0]        link_next;
  logic              emerg_next;
  logic [31:0]       interval_next;
  logic              param_pos;
  dpms_pkg::result_t res_a;
  dpms_pkg::result_t res_b;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !hold_vld && (!out_vld || out_ready);
  assign out_valid = out_vld;
  assign out_data  = out_reg;
  assign param_pos = !in_data.event_param[31] && (in_data.event_param != 32'sd0);

  // Per-event rules: first mode target, link, emergency, interval
  always_comb begin
    t1_en         = 1'b0;
    t1_target     = current_mode;
    link_next     = link_kind;
    emerg_next    = emergency_active;
    interval_next = report_interval;
    case (in_data.event_code)
      dpms_pkg::EV_BOOT: begin
        t1_en     = 1'b1;
        t1_target = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_TIMER_WAKE: begin
        t1_en     = (current_mode == dpms_pkg::MODE_SLEEP);
        t1_target = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_WIFI_UP: begin
        link_next = dpms_pkg::LINK_WIFI;
        t1_en     = 1'b1;
        t1_target = dpms_pkg::MODE_WIFI;
      end
      dpms_pkg::EV_WIFI_DOWN: begin
        if (link_kind == dpms_pkg::LINK_WIFI) begin
          link_next = dpms_pkg::LINK_NONE;
        end
        t1_en     = (current_mode == dpms_pkg::MODE_WIFI);
        t1_target = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_WIFI_FAIL: begin
        t1_en     = (link_kind != dpms_pkg::LINK_WIFI);
        t1_target = dpms_pkg::MODE_LTE;
      end
      dpms_pkg::EV_PPP_UP: begin
        link_next = dpms_pkg::LINK_PPP;
        t1_en     = (current_mode != dpms_pkg::MODE_ALARM);
        t1_target = dpms_pkg::MODE_LTE;
      end
      dpms_pkg::EV_PPP_DOWN: begin
        if (link_kind == dpms_pkg::LINK_PPP) begin
          link_next = dpms_pkg::LINK_NONE;
        end
      end
      dpms_pkg::EV_GPS_FIX, dpms_pkg::EV_GPS_TIMEOUT: begin
        t1_en     = (current_mode == dpms_pkg::MODE_GNSS);
        t1_target = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_EMERGENCY: begin
        emerg_next    = 1'b1;
        interval_next = anomaly_interval;
        t1_en         = 1'b1;
        t1_target     = dpms_pkg::MODE_ALARM;
      end
      dpms_pkg::EV_CLEARED: begin
        emerg_next    = 1'b0;
        interval_next = normal_interval;
        t1_en         = 1'b1;
        t1_target     = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_CHARGER_ON: begin
        t1_en     = 1'b1;
        t1_target = dpms_pkg::MODE_CHARGING;
      end
      dpms_pkg::EV_CHARGER_OFF: begin
        t1_en     = 1'b1;
        t1_target = dpms_pkg::MODE_SAMPLING;
      end
      dpms_pkg::EV_CLOUD_CMD: begin
        if (param_pos) begin
          interval_next = in_data.event_param;
        end
      end
      dpms_pkg::EV_SHUTDOWN: begin
        t1_en     = 1'b1;
        t1_target = dpms_pkg::MODE_OFF;
      end
      default: begin
      end
    endcase
  end

  // First transition, then the fall-back to location acquisition
  always_comb begin
    tr1      = t1_en && (t1_target != current_mode);
    mode1    = tr1 ? t1_target : current_mode;
    rule2_en = ((in_data.event_code == dpms_pkg::EV_WIFI_DOWN) ||
                (in_data.event_code == dpms_pkg::EV_WIFI_FAIL)) &&
               (link_next != dpms_pkg::LINK_WIFI) && !emerg_next;
    tr2       = rule2_en && (mode1 != dpms_pkg::MODE_GNSS);
    mode_next = tr2 ? dpms_pkg::MODE_GNSS : mode1;
  end

  // Build the result transactions for this event
  always_comb begin
    res_a.link_now      = link_next;
    res_a.emergency_now = emerg_next;
    res_a.interval_now  = interval_next;
    res_a.prev_mode     = current_mode;
    res_a.next_mode     = mode_next;
    res_a.transitioned  = tr1 || tr2;
    res_a.last          = 1'b1;
    res_b               = res_a;
    if (tr1 && tr2) begin
      res_a.next_mode = mode1;
      res_a.last      = 1'b0;
      res_b.prev_mode = mode1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_interval  <= dpms_pkg::NORMAL_INTERVAL_RST;
      anomaly_interval <= dpms_pkg::ANOMALY_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dpms_pkg::REG_NORMAL_INTERVAL:  normal_interval  <= cfg_data;
        dpms_pkg::REG_ANOMALY_INTERVAL: anomaly_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state update on each accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode     <= dpms_pkg::MODE_SLEEP;
      link_kind        <= dpms_pkg::LINK_NONE;
      emergency_active <= 1'b0;
      report_interval  <= dpms_pkg::NORMAL_INTERVAL_RST;
    end else if (in_fire) begin
      current_mode     <= mode_next;
      link_kind        <= link_next;
      emergency_active <= emerg_next;
      report_interval  <= interval_next;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      hold_vld <= 1'b0;
    end else if (in_fire) begin
      out_vld  <= 1'b1;
      hold_vld <= tr1 && tr2;
    end else if (hold_vld && out_ready) begin
      out_vld  <= 1'b1;
      hold_vld <= 1'b0;
    end else if (out_ready) begin
      out_vld  <= 1'b0;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_reg  <= res_a;
      hold_reg <= res_b;
    end else if (hold_vld && out_ready) begin
      out_reg  <= hold_reg;
    end
  end

endmodule
